[hw/rtl/mfde_pkg.sv]
// Shared types, constants and the glyph font for the frame buffer draw engine.
// No dependencies.
package mfde_pkg;

    localparam int DISP_WIDTH  = 128;
    localparam int DISP_PAGES  = 8;
    localparam int GLYPH_COLS  = 6;
    localparam int ROWS        = DISP_PAGES * 8;
    localparam int STORE_BYTES = DISP_WIDTH * DISP_PAGES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int PAGE_W      = $clog2(DISP_PAGES);
    localparam int COL_W       = $clog2(DISP_WIDTH);
    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] LAST_CODE  = 8'd126;

    typedef enum logic [2:0] {
        FN_CLEAR  = 3'd0,
        FN_PIXEL  = 3'd1,
        FN_GLYPH  = 3'd2,
        FN_HLINE  = 3'd3,
        FN_VLINE  = 3'd4,
        FN_RECT   = 3'd5,
        FN_FILL   = 3'd6,
        FN_READ   = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLOT_RD,
        ST_PLOT_WR,
        ST_BYTE_WR,
        ST_READ,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture command
        logic seg_init;   // set up walk of next segment
        logic plot_rd;    // issue read of current plot byte, advance
        logic plot_wr;    // write modified plot byte
        logic byte_wr;    // write whole byte (clear / glyph), advance
        logic rd_issue;   // issue read for read command
        logic finish;     // present result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;       // current walk step is the final one
        logic seg_last;   // current segment is the final one
        logic empty;      // current segment has nothing to do
        logic byte_mode;  // command writes whole bytes
        logic is_read;
    } dp_stat_t;

    // Glyph column bytes, 95 codes by 6 columns, code 32 first
    function automatic logic [7:0] glyph_col(input logic [6:0] sel, input logic [2:0] k);
        logic [47:0] g;
        case (sel)
            7'd0:  g = 48'h000000000000; 7'd1:  g = 48'h00005F000000;
            7'd2:  g = 48'h000700070000; 7'd3:  g = 48'h147F147F1400;
            7'd4:  g = 48'h242A7F2A1200; 7'd5:  g = 48'h231308646200;
            7'd6:  g = 48'h364956205000; 7'd7:  g = 48'h000807030000;
            7'd8:  g = 48'h001C22410000; 7'd9:  g = 48'h0041221C0000;
            7'd10: g = 48'h2A1C7F1C2A00; 7'd11: g = 48'h08083E080800;
            7'd12: g = 48'h008070300000; 7'd13: g = 48'h080808080800;
            7'd14: g = 48'h000060600000; 7'd15: g = 48'h201008040200;
            7'd16: g = 48'h3E5149453E00; 7'd17: g = 48'h00427F400000;
            7'd18: g = 48'h724949494600; 7'd19: g = 48'h2141494D3300;
            7'd20: g = 48'h1814127F1000; 7'd21: g = 48'h274545453900;
            7'd22: g = 48'h3C4A49493100; 7'd23: g = 48'h412111090700;
            7'd24: g = 48'h364949493600; 7'd25: g = 48'h464949291E00;
            7'd26: g = 48'h000014000000; 7'd27: g = 48'h004034000000;
            7'd28: g = 48'h000814224100; 7'd29: g = 48'h141414141400;
            7'd30: g = 48'h004122140800; 7'd31: g = 48'h020159090600;
            7'd32: g = 48'h3E415D594E00; 7'd33: g = 48'h7C1211127C00;
            7'd34: g = 48'h7F4949493600; 7'd35: g = 48'h3E4141412200;
            7'd36: g = 48'h7F4141413E00; 7'd37: g = 48'h7F4949494100;
            7'd38: g = 48'h7F0909090100; 7'd39: g = 48'h3E4149497A00;
            7'd40: g = 48'h7F0808087F00; 7'd41: g = 48'h00417F410000;
            7'd42: g = 48'h2040413F0100; 7'd43: g = 48'h7F0814224100;
            7'd44: g = 48'h7F4040404000; 7'd45: g = 48'h7F021C027F00;
            7'd46: g = 48'h7F0408107F00; 7'd47: g = 48'h3E4141413E00;
            7'd48: g = 48'h7F0909090600; 7'd49: g = 48'h3E4151215E00;
            7'd50: g = 48'h7F0919294600; 7'd51: g = 48'h264949493200;
            7'd52: g = 48'h03017F010300; 7'd53: g = 48'h3F4040403F00;
            7'd54: g = 48'h1F2040201F00; 7'd55: g = 48'h3F4038403F00;
            7'd56: g = 48'h631408146300; 7'd57: g = 48'h030478040300;
            7'd58: g = 48'h6159494D4300; 7'd59: g = 48'h007F41414100;
            7'd60: g = 48'h020408102000; 7'd61: g = 48'h004141417F00;
            7'd62: g = 48'h040201020400; 7'd63: g = 48'h404040404000;
            7'd64: g = 48'h000307080000; 7'd65: g = 48'h205454784000;
            7'd66: g = 48'h7F2844443800; 7'd67: g = 48'h384444442800;
            7'd68: g = 48'h384444287F00; 7'd69: g = 48'h385454541800;
            7'd70: g = 48'h00087E090200; 7'd71: g = 48'h18A4A49C7800;
            7'd72: g = 48'h7F0804047800; 7'd73: g = 48'h00447D400000;
            7'd74: g = 48'h2040403D0000; 7'd75: g = 48'h7F1028440000;
            7'd76: g = 48'h00417F400000; 7'd77: g = 48'h7C0478047800;
            7'd78: g = 48'h7C0804047800; 7'd79: g = 48'h384444443800;
            7'd80: g = 48'hFC1824241800; 7'd81: g = 48'h18242418FC00;
            7'd82: g = 48'h7C0804040800; 7'd83: g = 48'h485454542400;
            7'd84: g = 48'h04043F442400; 7'd85: g = 48'h3C4040207C00;
            7'd86: g = 48'h1C2040201C00; 7'd87: g = 48'h3C4030403C00;
            7'd88: g = 48'h442810284400; 7'd89: g = 48'h4C9090907C00;
            7'd90: g = 48'h4464544C4400; 7'd91: g = 48'h000836410000;
            7'd92: g = 48'h000077000000; 7'd93: g = 48'h004136080000;
            7'd94: g = 48'h020102040200;
            default: g = 48'h000000000000;
        endcase
        case (k)
            3'd0:    glyph_col = g[47:40];
            3'd1:    glyph_col = g[39:32];
            3'd2:    glyph_col = g[31:24];
            3'd3:    glyph_col = g[23:16];
            3'd4:    glyph_col = g[15:8];
            3'd5:    glyph_col = g[7:0];
            default: glyph_col = 8'h00;
        endcase
    endfunction

endpackage

[hw/rtl/mfde_ctrl.sv]
// Command sequencer for the frame buffer draw engine.
// Depends on mfde_pkg.
module mfde_ctrl
    import mfde_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     clr_busy,
    output logic     busy,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && !clr_busy)
                    state_next = ST_BYTE_WR;
            end
            ST_BYTE_WR:
            begin
                // start of each segment: dispatch; whole-byte commands stay here per byte
                if (stat.is_read)
                    state_next = ST_READ;
                else if (stat.byte_mode)
                    state_next = (stat.empty || stat.last) ? ST_DONE : ST_BYTE_WR;
                else if (stat.empty)
                    state_next = stat.seg_last ? ST_DONE : ST_BYTE_WR;
                else
                    state_next = ST_PLOT_WR;
            end
            ST_PLOT_RD: state_next = ST_PLOT_WR;
            ST_PLOT_WR:
            begin
                if (!stat.last)
                    state_next = ST_PLOT_RD;
                else if (stat.seg_last)
                    state_next = ST_DONE;
                else
                    state_next = ST_BYTE_WR;
            end
            ST_READ:    state_next = ST_DONE;
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        busy     = (state_reg != ST_IDLE) || clr_busy;
        case (state_reg)
            ST_IDLE:    cmd.load = start && !clr_busy;
            ST_BYTE_WR:
            begin
                if (stat.is_read)
                    cmd.rd_issue = 1'b1;
                else if (stat.byte_mode)
                    cmd.byte_wr = !stat.empty;
                else if (stat.empty)
                    cmd.seg_init = 1'b1;
                else
                    cmd.plot_rd = 1'b1;
            end
            ST_PLOT_RD: cmd.plot_rd = 1'b1;
            ST_PLOT_WR:
            begin
                cmd.plot_wr  = 1'b1;
                cmd.seg_init = stat.last && !stat.seg_last;
            end
            ST_READ, ST_DONE: ;
            default:    cmd = '0;
        endcase
        // present the result word on the cycle after the final step
        cmd.finish = (state_next == ST_DONE);
    end

endmodule

[hw/rtl/mfde_dp.sv]
// Datapath: command registers, walk counters, frame memory and result register.
// Depends on mfde_pkg.
module mfde_dp
    import mfde_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    output logic              clr_busy,
    input  logic [2:0]        func,
    input  logic [7:0]        x,
    input  logic [7:0]        y,
    input  logic [7:0]        extent_w,
    input  logic [7:0]        extent_h,
    input  logic              color,
    input  logic [7:0]        char_code,
    input  logic [2:0]        read_page,
    output logic [7:0]        read_data,
    output logic              read_valid,
    output logic              done
);

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] mem_q_reg;

    logic [2:0] func_reg;
    logic [7:0] x_reg, y_reg, w_reg, h_reg, code_reg;
    logic       color_reg;
    logic [2:0] rpage_reg;

    // segment: origin, span counters
    logic [1:0] seg_reg;
    logic [7:0] cx_reg, cy_reg, i_reg, j_reg, ni_reg, nj_reg;
    logic [ADDR_W-1:0] wa_reg;
    logic              wbit_ok_reg;
    logic [2:0]        wbit_reg;
    logic              plot_last_reg;

    // clearing pass at reset: sweep once
    logic [ADDR_W:0] sweep_reg;
    logic            clr_busy_reg;

    logic [7:0] rd_reg;
    logic       rv_reg, done_reg;

    func_t fn;
    assign fn = func_t'(func_reg);

    // Segment setup for pixel, line, fill and rect commands
    logic [7:0] s_cx, s_cy, s_ni, s_nj;
    logic       s_last;
    always_comb
    begin
        s_cx = x_reg; s_cy = y_reg; s_ni = w_reg; s_nj = 8'd1; s_last = 1'b1;
        case (fn)
            FN_HLINE: begin s_ni = w_reg; s_nj = 8'd1; end
            FN_VLINE: begin s_ni = 8'd1; s_nj = h_reg; end
            FN_FILL:  begin s_ni = w_reg; s_nj = h_reg; end
            FN_PIXEL: begin s_ni = 8'd1; s_nj = 8'd1; end
            FN_RECT:
            begin
                s_last = (seg_reg == 2'd3);
                case (seg_reg)
                    2'd0: begin s_ni = w_reg; s_nj = 8'd1; end
                    2'd1: begin s_cy = y_reg + h_reg + 8'hFF; s_ni = w_reg; s_nj = 8'd1; end
                    2'd2: begin s_ni = 8'd1; s_nj = h_reg; end
                    default:
                    begin
                        s_cx = x_reg + w_reg + 8'hFF; s_ni = 8'd1; s_nj = h_reg;
                    end
                endcase
            end
            default: ;
        endcase
    end

    logic seg_valid_reg;
    logic [7:0] ccx, ccy, ni_c, nj_c;
    assign ccx  = seg_valid_reg ? cx_reg : s_cx;
    assign ccy  = seg_valid_reg ? cy_reg : s_cy;
    assign ni_c = seg_valid_reg ? ni_reg : s_ni;
    assign nj_c = seg_valid_reg ? nj_reg : s_nj;

    logic [7:0] px, py;
    assign px = ccx + i_reg;
    assign py = ccy + j_reg;
    logic on_screen;
    assign on_screen = ({1'b0, px} < 9'(DISP_WIDTH)) && ({1'b0, py} < 9'(ROWS));
    logic [ADDR_W-1:0] paddr;
    assign paddr = ADDR_W'(32'(py[7:3]) * DISP_WIDTH + 32'(px));

    // glyph / clear byte mode
    logic [6:0] gsel;
    assign gsel = (code_reg < FIRST_CODE || code_reg > LAST_CODE) ? 7'd0
                  : 7'(code_reg - FIRST_CODE);
    logic glyph_ok;
    assign glyph_ok = (32'(y_reg[7:3]) < DISP_PAGES)
                      && (32'(x_reg) + GLYPH_COLS <= DISP_WIDTH);
    logic [ADDR_W-1:0] gaddr;
    assign gaddr = ADDR_W'(32'(y_reg[7:3]) * DISP_WIDTH + 32'(x_reg) + 32'(i_reg));

    logic seg_empty, step_last;
    assign seg_empty = (ni_c == 8'd0) || (nj_c == 8'd0);
    assign step_last = (i_reg == ni_c - 8'd1) && (j_reg == nj_c - 8'd1);

    // read result only for a read inside the frame
    logic rd_ok;
    assign rd_ok = (fn == FN_READ) && (32'(x_reg) < DISP_WIDTH)
                   && (32'(rpage_reg) < DISP_PAGES);

    always_comb
    begin
        stat.is_read   = (fn == FN_READ);
        stat.byte_mode = (fn == FN_CLEAR) || (fn == FN_GLYPH);
        stat.seg_last  = s_last;
        if (fn == FN_CLEAR)
        begin
            stat.empty = 1'b0;
            stat.last  = (32'(i_reg) + 32'(j_reg) * 256 == STORE_BYTES - 1);
        end
        else if (fn == FN_GLYPH)
        begin
            stat.empty = !glyph_ok;
            stat.last  = (32'(i_reg) == GLYPH_COLS - 1);
        end
        else
        begin
            // the step being written was the last of its segment
            stat.empty = seg_empty;
            stat.last  = plot_last_reg;
        end
    end

    logic [ADDR_W-1:0] caddr;
    assign caddr = ADDR_W'({j_reg, i_reg});

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            clr_busy_reg  <= 1'b1;
            done_reg      <= 1'b0;
            seg_valid_reg <= 1'b0;
            seg_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            plot_last_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (clr_busy_reg)
            begin
                sweep_reg <= sweep_reg + 1'b1;
                if (sweep_reg == (ADDR_W+1)'(STORE_BYTES - 1))
                    clr_busy_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                seg_reg <= '0; seg_valid_reg <= 1'b0; i_reg <= '0; j_reg <= '0;
            end
            if (cmd.seg_init)
            begin
                seg_reg <= seg_reg + 2'd1; seg_valid_reg <= 1'b0;
                i_reg <= '0; j_reg <= '0;
            end
            if (cmd.plot_rd)
            begin
                seg_valid_reg <= 1'b1;
                plot_last_reg <= step_last;
                cx_reg <= ccx; cy_reg <= ccy; ni_reg <= ni_c; nj_reg <= nj_c;
                if (i_reg == ni_c - 8'd1)
                begin
                    i_reg <= '0; j_reg <= j_reg + 8'd1;
                end
                else
                    i_reg <= i_reg + 8'd1;
            end
            if (cmd.byte_wr)
            begin
                if (fn == FN_CLEAR)
                    {j_reg, i_reg} <= {j_reg, i_reg} + 16'd1;
                else
                    i_reg <= i_reg + 8'd1;
            end
        end
    end

    // Command capture, plot address hold and result capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func; x_reg <= x; y_reg <= y; w_reg <= extent_w;
            h_reg <= extent_h; color_reg <= color; code_reg <= char_code;
            rpage_reg <= read_page;
        end
        if (cmd.plot_rd)
        begin
            wa_reg      <= paddr;
            wbit_reg    <= py[2:0];
            wbit_ok_reg <= on_screen;
        end
        if (cmd.finish)
        begin
            rv_reg <= rd_ok;
            rd_reg <= rd_ok ? mem_q_reg : 8'h00;
        end
        else if (done_reg)
            rv_reg <= 1'b0;
    end

    // Frame memory: one write port, one registered read port
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        mod_byte;
    assign raddr = cmd.rd_issue
                   ? ADDR_W'(32'(rpage_reg) * DISP_WIDTH + 32'(x_reg[COL_W-1:0]))
                   : paddr;
    always_comb
    begin
        mod_byte = mem_q_reg;
        if (fn == FN_PIXEL)
            mod_byte[wbit_reg] = color_reg;
        else
            mod_byte[wbit_reg] = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        mem_q_reg <= mem[raddr];
        if (clr_busy_reg)
            mem[sweep_reg[ADDR_W-1:0]] <= 8'h00;
        else if (cmd.plot_wr && wbit_ok_reg)
            mem[wa_reg] <= mod_byte;
        else if (cmd.byte_wr)
            mem[(fn == FN_CLEAR) ? caddr : gaddr] <=
                (fn == FN_CLEAR) ? 8'h00 : glyph_col(gsel, i_reg[2:0]);
    end

    assign clr_busy   = clr_busy_reg;
    assign done       = done_reg;
    assign read_data  = done_reg ? rd_reg : 8'h00;
    assign read_valid = done_reg && rv_reg && (fn == FN_READ);

endmodule

[hw/rtl/mono_framebuffer_draw_engine_unit.sv]
// Top level of the frame buffer draw engine: sequencer plus datapath.
// Depends on mfde_pkg, mfde_ctrl, mfde_dp.
//
// Usage: drive func and the operand ports and raise start while busy is low;
// the word is taken on that edge. busy stays high until the result word,
// marked by done for one cycle with read_data and read_valid, has been shown;
// the next word can be taken in the cycle after done.
// The receiver cannot stall; done is a single-cycle strobe.
// Clear writes one byte per cycle over the 1024 bytes. Glyph writes whole
// bytes and is dropped when it does not fit on screen. Pixel, lines, fill
// and rectangle outline walk their pixels by read-modify-write on the single
// frame memory port; off-screen pixels are still walked but not written.
// The frame memory port is the limit on all drawing commands.
// After reset the memory is swept to zero while busy stays high; no command
// is taken until that sweep ends.
module mono_framebuffer_draw_engine_unit
    import mfde_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       done,
    input  logic [2:0] func,
    input  logic [7:0] x,
    input  logic [7:0] y,
    input  logic [7:0] extent_w,
    input  logic [7:0] extent_h,
    input  logic       color,
    input  logic [7:0] char_code,
    input  logic [2:0] read_page,
    output logic [7:0] read_data,
    output logic       read_valid
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     clr_busy;

    mfde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .clr_busy (clr_busy),
        .busy     (busy),
        .stat     (stat),
        .cmd      (cmd)
    );

    mfde_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .clr_busy   (clr_busy),
        .func       (func),
        .x          (x),
        .y          (y),
        .extent_w   (extent_w),
        .extent_h   (extent_h),
        .color      (color),
        .char_code  (char_code),
        .read_page  (read_page),
        .read_data  (read_data),
        .read_valid (read_valid),
        .done       (done)
    );

endmodule

[hw/rtl/mfde_checker.sv]
// Port checker for the frame buffer draw engine, bound to the top level.
// Depends on mfde_pkg.
module mfde_port_props
    import mfde_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [7:0] read_data,
    input logic       read_valid
);

    // done is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");

    // result shown only while busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done outside busy");

    // a valid read only with done
    a_valid_done: assert property (@(posedge clk) disable iff (!rst_n)
        read_valid |-> done) else $error("read_valid without done");

    // accepted word makes busy on next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accept without busy");

    // data zero when not valid
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !read_valid |-> (read_data == 8'h00)) else $error("stray read data");

endmodule

bind mono_framebuffer_draw_engine_unit mfde_port_props u_mfde_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .read_data  (read_data),
    .read_valid (read_valid)
);

[sim/mfde_checker.sv]
// Result checker for the frame buffer draw engine: keeps its own image of the
// frame, predicts each result word and compares it. Depends on mfde_pkg.
`timescale 1ns / 1ps

module mfde_checker
    import mfde_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       done,
    input  logic [2:0] func,
    input  logic [7:0] x,
    input  logic [7:0] y,
    input  logic [7:0] extent_w,
    input  logic [7:0] extent_h,
    input  logic       color,
    input  logic [7:0] char_code,
    input  logic [2:0] read_page,
    input  logic [7:0] read_data,
    input  logic       read_valid,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
    } result_t;

    logic [7:0] frame_img [STORE_BYTES];
    result_t    awaited_q [$];

    assign pending = awaited_q.size();

    // Set or clear one dot, dropping anything off screen
    function automatic void plot_dot(int col, int row, logic lit);
        int at;
        if (col >= DISP_WIDTH || row >= ROWS)
            return;
        at = (row / 8) * DISP_WIDTH + col;
        frame_img[at][row % 8] = lit;
    endfunction

    function automatic void plot_hrun(int col, int row, int len);
        for (int k = 0; k < len; k++)
            plot_dot((col + k) & 8'hFF, row & 8'hFF, 1'b1);
    endfunction

    function automatic void plot_vrun(int col, int row, int len);
        for (int k = 0; k < len; k++)
            plot_dot(col & 8'hFF, (row + k) & 8'hFF, 1'b1);
    endfunction

    // Font held locally, code 32 first, column 0 in the top byte
    function automatic logic [47:0] glyph_bits(int sel);
        logic [47:0] font [95] = '{
            48'h000000000000, 48'h00005F000000, 48'h000700070000, 48'h147F147F1400,
            48'h242A7F2A1200, 48'h231308646200, 48'h364956205000, 48'h000807030000,
            48'h001C22410000, 48'h0041221C0000, 48'h2A1C7F1C2A00, 48'h08083E080800,
            48'h008070300000, 48'h080808080800, 48'h000060600000, 48'h201008040200,
            48'h3E5149453E00, 48'h00427F400000, 48'h724949494600, 48'h2141494D3300,
            48'h1814127F1000, 48'h274545453900, 48'h3C4A49493100, 48'h412111090700,
            48'h364949493600, 48'h464949291E00, 48'h000014000000, 48'h004034000000,
            48'h000814224100, 48'h141414141400, 48'h004122140800, 48'h020159090600,
            48'h3E415D594E00, 48'h7C1211127C00, 48'h7F4949493600, 48'h3E4141412200,
            48'h7F4141413E00, 48'h7F4949494100, 48'h7F0909090100, 48'h3E4149497A00,
            48'h7F0808087F00, 48'h00417F410000, 48'h2040413F0100, 48'h7F0814224100,
            48'h7F4040404000, 48'h7F021C027F00, 48'h7F0408107F00, 48'h3E4141413E00,
            48'h7F0909090600, 48'h3E4151215E00, 48'h7F0919294600, 48'h264949493200,
            48'h03017F010300, 48'h3F4040403F00, 48'h1F2040201F00, 48'h3F4038403F00,
            48'h631408146300, 48'h030478040300, 48'h6159494D4300, 48'h007F41414100,
            48'h020408102000, 48'h004141417F00, 48'h040201020400, 48'h404040404000,
            48'h000307080000, 48'h205454784000, 48'h7F2844443800, 48'h384444442800,
            48'h384444287F00, 48'h385454541800, 48'h00087E090200, 48'h18A4A49C7800,
            48'h7F0804047800, 48'h00447D400000, 48'h2040403D0000, 48'h7F1028440000,
            48'h00417F400000, 48'h7C0478047800, 48'h7C0804047800, 48'h384444443800,
            48'hFC1824241800, 48'h18242418FC00, 48'h7C0804040800, 48'h485454542400,
            48'h04043F442400, 48'h3C4040207C00, 48'h1C2040201C00, 48'h3C4030403C00,
            48'h442810284400, 48'h4C9090907C00, 48'h4464544C4400, 48'h000836410000,
            48'h000077000000, 48'h004136080000, 48'h020102040200
        };
        return font[sel];
    endfunction

    // Apply one command word to the image and return the expected result
    function automatic result_t apply_command(func_t f, int cx, int cy, int cw, int ch,
                                              logic lit, int code, int pg);
        result_t r;
        logic [47:0] g;
        int sel;
        r = '0;
        case (f)
            FN_CLEAR: foreach (frame_img[i]) frame_img[i] = 8'h00;
            FN_PIXEL: plot_dot(cx, cy, lit);
            FN_GLYPH:
            begin
                sel = (code < 32 || code > 126) ? 0 : code - 32;
                g = glyph_bits(sel);
                if ((cy / 8) < DISP_PAGES && cx + GLYPH_COLS <= DISP_WIDTH)
                    for (int k = 0; k < GLYPH_COLS; k++)
                        frame_img[(cy / 8) * DISP_WIDTH + cx + k] = g[47 - 8 * k -: 8];
            end
            FN_HLINE: plot_hrun(cx, cy, cw);
            FN_VLINE: plot_vrun(cx, cy, ch);
            FN_RECT:
            begin
                plot_hrun(cx, cy, cw);
                plot_hrun(cx, (cy + ch + 255) & 8'hFF, cw);
                plot_vrun(cx, cy, ch);
                plot_vrun((cx + cw + 255) & 8'hFF, cy, ch);
            end
            FN_FILL:
                for (int i = 0; i < cw; i++)
                    for (int j = 0; j < ch; j++)
                        plot_dot((cx + i) & 8'hFF, (cy + j) & 8'hFF, 1'b1);
            default:
                if (cx < DISP_WIDTH && pg < DISP_PAGES)
                begin
                    r.data  = frame_img[pg * DISP_WIDTH + cx];
                    r.valid = 1'b1;
                end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s mismatch: got %0h, want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        foreach (frame_img[i]) frame_img[i] = 8'h00;
    end

    // Predict on each accepted command word, check each done strobe
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_q.size() == 0)
                    report_mismatch("unexpected word", read_data, 0);
                else
                begin
                    want = awaited_q.pop_front();
                    if (read_data !== want.data)
                        report_mismatch("read_data", read_data, want.data);
                    if (read_valid !== want.valid)
                        report_mismatch("read_valid", read_valid, want.valid);
                end
            end
            if (start && !busy)
                awaited_q.push_back(apply_command(func_t'(func), x, y, extent_w, extent_h,
                                                  color, char_code, read_page));
        end
    end

endmodule

[sim/tb_mono_framebuffer_draw_engine_unit.sv]
// Stimulus and verdict for the frame buffer draw engine.
// Depends on mfde_pkg, mono_framebuffer_draw_engine_unit and mfde_checker.
`timescale 1ns / 1ps

module tb_mono_framebuffer_draw_engine_unit;
    import mfde_pkg::*;

    localparam int RANDOM_WORDS = 560;
    localparam longint CYCLE_LIMIT = 4_000_000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       done;
    logic [2:0] func;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] extent_w;
    logic [7:0] extent_h;
    logic       color;
    logic [7:0] char_code;
    logic [2:0] read_page;
    logic [7:0] read_data;
    logic       read_valid;
    int         fail_count;
    int         pending;
    longint     cycle_count;

    mono_framebuffer_draw_engine_unit dut (.*);

    mfde_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hold the run to a generous cycle budget
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_mono_framebuffer_draw_engine_unit: done, errors");
            $finish;
        end
    end

    // Present one word and hold it until taken
    task automatic send_word(func_t f, logic [7:0] cx, logic [7:0] cy, logic [7:0] cw,
                             logic [7:0] ch, logic lit, logic [7:0] code, logic [2:0] pg);
        func      <= f;
        x         <= cx;
        y         <= cy;
        extent_w  <= cw;
        extent_h  <= ch;
        color     <= lit;
        char_code <= code;
        read_page <= pg;
        start     <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Random word, sizes kept mostly small so fills stay short
    task automatic send_random;
        func_t f;
        logic [7:0] cw, ch;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)       f = FN_CLEAR;
        else if (pick < 30) f = FN_READ;
        else                f = func_t'($urandom_range(1, 6));
        cw = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
        ch = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
        if (f == FN_FILL && cw * ch > 400)
            ch = 8'($urandom_range(0, 2));
        send_word(f,
                  ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127)),
                  ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 63)),
                  cw, ch, 1'($urandom), 8'($urandom), 3'($urandom));
    endtask

    initial
    begin
        int sent;
        int guard;
        cycle_count = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        func      = FN_READ;
        x         = '0;
        y         = '0;
        extent_w  = '0;
        extent_h  = '0;
        color     = 1'b0;
        char_code = '0;
        read_page = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every command and the corner cases
        send_word(FN_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   3'd0);
        send_word(FN_PIXEL, 8'd127, 8'd63,  8'd0,   8'd0,   1'b1, 8'd0,   3'd0);
        send_word(FN_READ,  8'd127, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   3'd7);
        send_word(FN_PIXEL, 8'd128, 8'd64,  8'd0,   8'd0,   1'b1, 8'd0,   3'd0);
        send_word(FN_PIXEL, 8'd127, 8'd63,  8'd0,   8'd0,   1'b0, 8'd0,   3'd0);
        send_word(FN_GLYPH, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd65,  3'd0);
        send_word(FN_READ,  8'd2,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   3'd0);
        send_word(FN_GLYPH, 8'd122, 8'd63,  8'd0,   8'd0,   1'b0, 8'd126, 3'd0);
        send_word(FN_GLYPH, 8'd123, 8'd8,   8'd0,   8'd0,   1'b0, 8'd66,  3'd0);
        send_word(FN_GLYPH, 8'd10,  8'd64,  8'd0,   8'd0,   1'b0, 8'd66,  3'd0);
        send_word(FN_GLYPH, 8'd10,  8'd8,   8'd0,   8'd0,   1'b0, 8'd255, 3'd0);
        send_word(FN_HLINE, 8'd250, 8'd5,   8'd20,  8'd0,   1'b0, 8'd0,   3'd0);
        send_word(FN_VLINE, 8'd3,   8'd250, 8'd0,   8'd20,  1'b0, 8'd0,   3'd0);
        send_word(FN_RECT,  8'd40,  8'd20,  8'd0,   8'd0,   1'b0, 8'd0,   3'd0);
        send_word(FN_RECT,  8'd60,  8'd30,  8'd10,  8'd8,   1'b0, 8'd0,   3'd0);
        send_word(FN_FILL,  8'd100, 8'd60,  8'd40,  8'd10,  1'b0, 8'd0,   3'd0);
        send_word(FN_FILL,  8'd0,   8'd0,   8'd255, 8'd0,   1'b0, 8'd0,   3'd0);
        send_word(FN_READ,  8'd100, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   3'd7);
        send_word(FN_READ,  8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   3'd7);
        send_word(FN_HLINE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd31,  3'd7);
        send_word(FN_CLEAR, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   3'd0);
        send_word(FN_READ,  8'd2,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   3'd0);

        // Random: bursts of words with random gaps, some bursts back to back
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            repeat ($urandom_range(1, 12))
            begin
                send_random();
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 20));
        end
        start <= 1'b0;

        // Drain, then allow a few settling cycles
        guard = 0;
        while (pending != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_mono_framebuffer_draw_engine_unit: done, clean");
        else
            $display("tb_mono_framebuffer_draw_engine_unit: done, errors");
        $finish;
    end

endmodule

[mono_framebuffer_draw_engine_unit.f]
hw/rtl/mfde_pkg.sv
hw/rtl/mfde_ctrl.sv
hw/rtl/mfde_dp.sv
hw/rtl/mono_framebuffer_draw_engine_unit.sv
hw/rtl/mfde_checker.sv
sim/mfde_checker.sv
sim/tb_mono_framebuffer_draw_engine_unit.sv
